FILE: sv/lamp_power_and_energy_meter_assert.svh
// Assertion macros for the lamp power and energy meter.
`ifndef LAMP_POWER_AND_ENERGY_METER_ASSERT_SVH
`define LAMP_POWER_AND_ENERGY_METER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define LPEM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define LPEM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/lpem_pkg.sv
// Shared types, constants and efficiency tables of the lamp power and energy meter.
package lpem_pkg;

    // field widths
    localparam int ADC_W    = 16;
    localparam int LVL_W    = 8;
    localparam int POWER_W  = 13;
    localparam int REM_W    = 12;
    localparam int SUM_W    = 48;
    localparam int SCALED_W = 14;   // scaled current / voltage
    localparam int TOTAL_W  = 16;   // remainder + 5 * power
    localparam int DIVD_W   = 28;   // product of scaled current and voltage
    localparam int DIVS_W   = 17;   // efficiency range
    localparam int IN_W     = 41;   // packed input fields
    localparam int OUT_W    = 64;   // packed result fields, byte padded

    localparam logic [POWER_W-1:0]  POWER_MAX   = 13'd8191;
    localparam logic [SCALED_W-1:0] CUR_OFFSET  = 14'd10;
    localparam logic [SCALED_W-1:0] DEADBAND    = 14'd10;
    localparam logic [DIVS_W-1:0]   ENERGY_UNIT = 17'd3600;
    localparam logic [11:0]         VOLT_GAIN   = 12'd3671;

    // floor(n/27)    = (n * M_DIV27)  >> 32 for n < 2^19
    // floor(n/10000) = ((n >> 4) * M_DIV625) >> 41 for n < 2^27
    // floor(n/3600)  = ((n >> 4) * M_DIV225) >> 20 for n < 2^16
    localparam logic [27:0] M_DIV27  = 28'd159072863;
    localparam logic [31:0] M_DIV625 = 32'd3518437209;
    localparam logic [12:0] M_DIV225 = 13'd4661;

    typedef logic [255:0][DIVS_W-1:0] eff_tbl_t;

    // Efficiency per dimming level; never zero for levels 1..255,
    // level 0 is unused (power forced to zero).
    function automatic eff_tbl_t eff_table(input logic whitest);
        eff_tbl_t    tbl;
        int unsigned sq;
        int unsigned e;
        for (int lvl = 0; lvl < 256; lvl++)
        begin
            sq = lvl * lvl;
            if (whitest)
                e = 295 * lvl + 39876 - (sq * 5446 / 10000);
            else
                e = (42332 * lvl / 100) + 27991 - (sq * 8855 / 10000);
            tbl[lvl] = DIVS_W'(e);
        end
        return tbl;
    endfunction

    localparam eff_tbl_t EFF_WHITE = eff_table(1'b1);
    localparam eff_tbl_t EFF_WARM  = eff_table(1'b0);

    typedef struct packed {
        logic capture;    // latch input transaction
        logic mul1;       // first multiply stage
        logic mul2;       // second multiply stage
        logic mul3;       // product stage
        logic div_start;  // launch divider
        logic finish;     // commit state, load result
    } ctrl_cmd_t;

    typedef struct packed {
        logic div_done;   // divider result valid
        logic out_hold;   // result register still occupied
    } dp_status_t;

endpackage

FILE: sv/lamp_power_and_energy_meter.sv
// Top level of the lamp power and energy meter: stream ports, controller, datapath.
//
// Each input transaction is either a power sample (tuser = 0) or a five second energy
// tick (tuser = 1) and yields exactly one result transaction. A sample scales the
// current reading by 10/27 plus an offset of 10 and the voltage reading by 3671/10000
// (truncated, negatives clamped to zero), multiplies them and divides by a dimming-level
// efficiency taken from one of two constant curves; cfg_data selects the whitest curve.
// A lamp that is off or at level zero draws zero power. The reported power follows the
// new value only when it moves by more than 10, and report_changed flags that. A tick
// adds five times the reported power to a remainder and carries whole multiples of 3600
// into the 48-bit wrapping energy total. Items are handled one at a time, each through
// three multiply stages, the divider launch, a wait on the 28-step restoring divider
// of the power division and the commit; a tick runs the same fixed sequence. The
// result register lets the next input transaction be taken while an earlier result
// still waits on m_tready.
// Write cfg_data only while the block is idle; it is always ready.
module lamp_power_and_energy_meter (
    input  logic         clk,
    input  logic         rst_n,

    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // current_adc[15:0], voltage_adc[31:16],
                                    // lamp_on[32], dim_level[40:33], zero pad
    input  logic         s_tuser,   // mode: 0 = power sample, 1 = energy tick

    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // reported_power[12:0], report_changed[13],
                                    // energy_total[61:14], zero pad

    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_data   // whitest_curve
);

    lpem_pkg::ctrl_cmd_t   cmd;
    lpem_pkg::dp_status_t  status;

    // the mode register is a single flop, always writable
    assign cfg_ready = 1'b1;

    lpem_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lpem_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_mode   (s_tuser),
        .in_data   (s_tdata[lpem_pkg::IN_W-1:0]),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (m_tdata)
    );

`include "lamp_power_and_energy_meter_assert.svh"

    // one item in flight: an accepted transaction closes the input
    `LPEM_ASSERT_NEXT(a_single_item, s_tvalid && s_tready, !s_tready, "input reopened after accept")

    // the divider only reports a result while an item is being worked on
    `LPEM_ASSERT_NOW(a_div_in_item, status.div_done, !s_tready, "divider done while idle")

    // committing a result returns the controller to idle
    `LPEM_ASSERT_NEXT(a_finish_idle, cmd.finish, s_tready && m_tvalid, "no idle after commit")

endmodule

FILE: sv/lpem_ctrl.sv
// Controller state machine sequencing one item through the datapath.
module lpem_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  lpem_pkg::dp_status_t  status,
    output lpem_pkg::ctrl_cmd_t   cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL1 = 3'd1;
    localparam logic [2:0] ST_MUL2 = 3'd2;
    localparam logic [2:0] ST_MUL3 = 3'd3;
    localparam logic [2:0] ST_DIVS = 3'd4;
    localparam logic [2:0] ST_DIVW = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                    state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = ST_MUL3;
            end
            ST_MUL3:
            begin
                cmd.mul3   = 1'b1;
                state_next = ST_DIVS;
            end
            ST_DIVS:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIVW;
            end
            ST_DIVW:
            begin
                if (status.div_done)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!status.out_hold)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

FILE: sv/lpem_div.sv
// Restoring divider, one quotient bit per cycle.
module lpem_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [lpem_pkg::DIVD_W-1:0]   dividend,
    input  logic [lpem_pkg::DIVS_W-1:0]   divisor,
    output logic                          done,
    output logic [lpem_pkg::DIVD_W-1:0]   quotient
);

    localparam int CNT_W = $clog2(lpem_pkg::DIVD_W + 1);

    logic                          busy_reg;
    logic                          done_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [lpem_pkg::DIVD_W-1:0]   quo_reg;
    logic [lpem_pkg::DIVS_W-1:0]   rem_reg;
    logic [lpem_pkg::DIVS_W-1:0]   divisor_reg;

    logic [lpem_pkg::DIVS_W:0]     trial;
    logic                          fits;

    assign trial = {rem_reg, quo_reg[lpem_pkg::DIVD_W-1]};
    assign fits  = (trial >= {1'b0, divisor_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(lpem_pkg::DIVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg     <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[lpem_pkg::DIVD_W-2:0], fits};
            if (fits)
                rem_reg <= lpem_pkg::DIVS_W'(trial - {1'b0, divisor_reg});
            else
                rem_reg <= trial[lpem_pkg::DIVS_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;

endmodule

FILE: sv/lpem_datapath.sv
// Datapath: scaling multipliers, efficiency lookup, divider, meter state, result register.
module lpem_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lpem_pkg::ctrl_cmd_t           cmd,
    output lpem_pkg::dp_status_t          status,
    input  logic                          in_mode,
    input  logic [lpem_pkg::IN_W-1:0]     in_data,
    input  logic                          cfg_valid,
    input  logic                          cfg_data,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic [lpem_pkg::OUT_W-1:0]    out_data
);

    // captured item
    logic                                 mode_reg;
    logic [lpem_pkg::ADC_W-1:0]           cur_reg;
    logic [lpem_pkg::ADC_W-1:0]           volt_reg;
    logic                                 on_reg;
    logic [lpem_pkg::LVL_W-1:0]           lvl_reg;

    // pipeline of the sample arithmetic
    logic [46:0]                          c_mul_reg;
    logic                                 c_neg_reg;
    logic [26:0]                          v_mul_reg;
    logic [lpem_pkg::SCALED_W-1:0]        ci_reg;
    logic [lpem_pkg::SCALED_W-1:0]        vi_reg;
    logic [lpem_pkg::DIVD_W-1:0]          prod_reg;
    logic [lpem_pkg::DIVS_W-1:0]          eff_reg;
    logic                                 zero_reg;
    logic [lpem_pkg::TOTAL_W-1:0]         total_reg;
    logic [4:0]                           tick_quo_reg;
    logic [lpem_pkg::REM_W-1:0]           tick_rem_reg;

    // meter state
    logic                                 whitest_reg;
    logic [lpem_pkg::POWER_W-1:0]         last_power_reg;
    logic [lpem_pkg::REM_W-1:0]           remainder_reg;
    logic [lpem_pkg::SUM_W-1:0]           energy_sum_reg;

    // result register
    logic                                 out_valid_reg;
    logic [lpem_pkg::OUT_W-1:0]           out_data_reg;

    logic [lpem_pkg::ADC_W-1:0]           cur_abs;
    logic [18:0]                          cur_x10;
    logic [14:0]                          volt_pos;
    logic [14:0]                          c_quo;
    logic [54:0]                          v_scaled;
    logic [lpem_pkg::SCALED_W-1:0]        ci_next;
    logic [24:0]                          tick_scaled;

    logic                                 div_done;
    logic [lpem_pkg::DIVD_W-1:0]          div_quo;
    logic [lpem_pkg::DIVD_W-1:0]          div_dividend;
    logic [lpem_pkg::DIVS_W-1:0]          div_divisor;

    logic [lpem_pkg::POWER_W-1:0]         power;
    logic signed [lpem_pkg::SCALED_W:0]   power_diff;
    logic                                 moved;
    logic [lpem_pkg::POWER_W-1:0]         last_power_next;
    logic [lpem_pkg::SUM_W-1:0]           energy_sum_next;

    // --- stage 1: |current| * 10 * (1/27), voltage * 3671
    assign cur_abs  = cur_reg[lpem_pkg::ADC_W-1] ? (~cur_reg + 1'b1) : cur_reg;
    assign cur_x10  = {cur_abs, 3'b000} + {2'b00, cur_abs, 1'b0};
    assign volt_pos = volt_reg[lpem_pkg::ADC_W-1] ? 15'd0 : volt_reg[14:0];

    // --- stage 2: truncated quotient toward zero plus offset, clamped
    assign c_quo = c_mul_reg[46:32];

    always_comb
    begin
        if (c_neg_reg)
        begin
            if (c_quo > 15'(lpem_pkg::CUR_OFFSET))
                ci_next = '0;
            else
                ci_next = lpem_pkg::CUR_OFFSET - c_quo[lpem_pkg::SCALED_W-1:0];
        end
        else
        begin
            ci_next = c_quo[lpem_pkg::SCALED_W-1:0] + lpem_pkg::CUR_OFFSET;
        end
    end

    assign v_scaled = 55'(v_mul_reg[26:4]) * 55'(lpem_pkg::M_DIV625);

    // tick: floor(total / 3600) by reciprocal, remainder one stage later
    assign tick_scaled = 25'(total_reg[lpem_pkg::TOTAL_W-1:4]) * 25'(lpem_pkg::M_DIV225);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= in_mode;
            cur_reg  <= in_data[15:0];
            volt_reg <= in_data[31:16];
            on_reg   <= in_data[32];
            lvl_reg  <= in_data[40:33];
        end
        if (cmd.mul1)
        begin
            c_mul_reg <= 47'(cur_x10) * 47'(lpem_pkg::M_DIV27);
            c_neg_reg <= cur_reg[lpem_pkg::ADC_W-1];
            v_mul_reg <= 27'(volt_pos) * 27'(lpem_pkg::VOLT_GAIN);
            eff_reg   <= whitest_reg ? lpem_pkg::EFF_WHITE[lvl_reg]
                                     : lpem_pkg::EFF_WARM[lvl_reg];
            zero_reg  <= !on_reg || (lvl_reg == '0);
            total_reg <= lpem_pkg::TOTAL_W'({4'b0000, remainder_reg}
                         + {1'b0, last_power_reg, 2'b00}
                         + {3'b000, last_power_reg});
        end
        if (cmd.mul2)
        begin
            ci_reg       <= ci_next;
            vi_reg       <= v_scaled[54:41];
            tick_quo_reg <= tick_scaled[24:20];
        end
        if (cmd.mul3)
        begin
            prod_reg     <= lpem_pkg::DIVD_W'(ci_reg) * lpem_pkg::DIVD_W'(vi_reg);
            tick_rem_reg <= lpem_pkg::REM_W'(total_reg
                            - lpem_pkg::TOTAL_W'(tick_quo_reg)
                            * lpem_pkg::TOTAL_W'(lpem_pkg::ENERGY_UNIT));
        end
    end

    // --- divider: power / efficiency
    assign div_dividend = prod_reg;
    assign div_divisor  = eff_reg;

    lpem_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo)
    );

    // --- finish: saturate, deadband, energy carry
    always_comb
    begin
        if (zero_reg)
            power = '0;
        else if (div_quo > lpem_pkg::DIVD_W'(lpem_pkg::POWER_MAX))
            power = lpem_pkg::POWER_MAX;
        else
            power = div_quo[lpem_pkg::POWER_W-1:0];
    end

    assign power_diff = $signed({2'b00, power}) - $signed({2'b00, last_power_reg});
    assign moved      = !mode_reg
                        && ((power_diff > $signed({1'b0, lpem_pkg::DEADBAND}))
                        ||  (power_diff < -$signed({1'b0, lpem_pkg::DEADBAND})));

    assign last_power_next = moved ? power : last_power_reg;
    assign energy_sum_next = mode_reg ? (energy_sum_reg + lpem_pkg::SUM_W'(tick_quo_reg))
                                      : energy_sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            whitest_reg    <= 1'b0;
            last_power_reg <= '0;
            remainder_reg  <= '0;
            energy_sum_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                whitest_reg <= cfg_data;
            if (cmd.finish)
            begin
                last_power_reg <= last_power_next;
                energy_sum_reg <= energy_sum_next;
                if (mode_reg)
                    remainder_reg <= tick_rem_reg;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
            out_data_reg <= {2'b00, energy_sum_next, moved, last_power_next};
    end

    assign status.div_done = div_done;
    assign status.out_hold = out_valid_reg && !out_ready;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;

endmodule
